// ===== src/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and codes of the segment table crossing test block.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int FUNC_W      = 2;
  localparam int INDEX_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 8;

  typedef logic [FUNC_W-1:0]      func_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  // Item functions
  localparam func_t FUNC_SEGMENT = 2'd0;
  localparam func_t FUNC_RECT    = 2'd1;
  localparam func_t FUNC_TEST    = 2'd2;

  // Result status codes
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_BAD_INDEX = 2'd2;

endpackage

// ===== src/stc_cross_eval.sv =====
// ----------------------------------------------------------------------------
// stc_cross_eval
// Two-stage crossing evaluator: cross products and bounding-box checks in the
// first stage, signs and the crossing decision in the second.
// ----------------------------------------------------------------------------
module stc_cross_eval #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] dx,
  input  logic signed [COORD_BITS-1:0] dy,
  output logic                         done,
  output logic                         crossing
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic signed [DW-1:0] ba_x, ba_y, ca_x, ca_y, da_x, da_y;
  logic signed [DW-1:0] dc_x, dc_y, ac_x, ac_y, bc_x, bc_y;
  logic                 c_in_ab, d_in_ab, a_in_cd, b_in_cd;

  logic signed [PW-1:0] prod [8];
  logic                 box_q [4];
  logic                 stage1_valid;

  logic signed [XW-1:0] x1, x2, x3, x4;
  logic                 proper, touch;

  always_comb begin
    ba_x = DW'(bx) - DW'(ax);
    ba_y = DW'(by) - DW'(ay);
    ca_x = DW'(cx) - DW'(ax);
    ca_y = DW'(cy) - DW'(ay);
    da_x = DW'(dx) - DW'(ax);
    da_y = DW'(dy) - DW'(ay);
    dc_x = DW'(dx) - DW'(cx);
    dc_y = DW'(dy) - DW'(cy);
    ac_x = DW'(ax) - DW'(cx);
    ac_y = DW'(ay) - DW'(cy);
    bc_x = DW'(bx) - DW'(cx);
    bc_y = DW'(by) - DW'(cy);
    // A collinear point lies on a segment exactly when it sits in its bounding box
    c_in_ab = ((cx >= ax && cx <= bx) || (cx >= bx && cx <= ax)) &&
              ((cy >= ay && cy <= by) || (cy >= by && cy <= ay));
    d_in_ab = ((dx >= ax && dx <= bx) || (dx >= bx && dx <= ax)) &&
              ((dy >= ay && dy <= by) || (dy >= by && dy <= ay));
    a_in_cd = ((ax >= cx && ax <= dx) || (ax >= dx && ax <= cx)) &&
              ((ay >= cy && ay <= dy) || (ay >= dy && ay <= cy));
    b_in_cd = ((bx >= cx && bx <= dx) || (bx >= dx && bx <= cx)) &&
              ((by >= cy && by <= dy) || (by >= dy && by <= cy));
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod[0]  <= ba_x * ca_y;
      prod[1]  <= ba_y * ca_x;
      prod[2]  <= ba_x * da_y;
      prod[3]  <= ba_y * da_x;
      prod[4]  <= dc_x * ac_y;
      prod[5]  <= dc_y * ac_x;
      prod[6]  <= dc_x * bc_y;
      prod[7]  <= dc_y * bc_x;
      box_q[0] <= c_in_ab;
      box_q[1] <= d_in_ab;
      box_q[2] <= a_in_cd;
      box_q[3] <= b_in_cd;
    end
  end

  always_comb begin
    x3 = XW'(prod[0]) - XW'(prod[1]);
    x4 = XW'(prod[2]) - XW'(prod[3]);
    x1 = XW'(prod[4]) - XW'(prod[5]);
    x2 = XW'(prod[6]) - XW'(prod[7]);
    proper = (((x1 > 0) && (x2 < 0)) || ((x1 < 0) && (x2 > 0))) &&
             (((x3 > 0) && (x4 < 0)) || ((x3 < 0) && (x4 > 0)));
    touch  = ((x3 == 0) && box_q[0]) || ((x4 == 0) && box_q[1]) ||
             ((x1 == 0) && box_q[2]) || ((x2 == 0) && box_q[3]);
  end

  always_ff @(posedge clk) begin
    if (stage1_valid) begin
      crossing <= proper || touch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      done         <= 1'b0;
    end else begin
      stage1_valid <= start;
      done         <= stage1_valid;
    end
  end

endmodule

// ===== src/segment_table_crossing_test.sv =====
// ----------------------------------------------------------------------------
// segment_table_crossing_test
// Table of wall segments with append and query-crossing test.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one word per item: func
//   selects store segment, store rectangle edges or test a query segment
//   against the stored entry entry_index. The output channel (out_valid /
//   out_stall) returns one result word per item: crossing, status and the
//   stored segment count after the item.
//   Items are handled one at a time. From accept, a rejected store, a bad
//   index or an unused func goes straight to the result; a segment store
//   writes one table entry; a rectangle store writes one entry per edge;
//   a test reads the table, then runs the product and decision stages.
//   The result word is loaded into the output register as the block returns
//   to idle, so out_valid rises in the cycle in which it can take the next
//   word.
//   The table is a single-port-write, registered-read memory; only entries
//   below the stored count are tested, so it needs no clearing after reset.
//   Reset empties the table count and drops any pending result. While the
//   receiver stalls, the result word holds; the next item may still be taken
//   and processed, and waits for the output register before finishing.
// ----------------------------------------------------------------------------
module segment_table_crossing_test #(
  parameter int MAX_SEGMENTS = 128,
  parameter int COORD_BITS   = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  stc_pkg::func_t               func,
  input  stc_pkg::index_t              entry_index,
  input  logic signed [COORD_BITS-1:0] point_a_x,
  input  logic signed [COORD_BITS-1:0] point_a_y,
  input  logic signed [COORD_BITS-1:0] point_b_x,
  input  logic signed [COORD_BITS-1:0] point_b_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         crossing,
  output stc_pkg::status_t             status,
  output stc_pkg::count_out_t          stored_count
);

  import stc_pkg::*;

  localparam int AW   = $clog2(MAX_SEGMENTS);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int EW   = 4 * COORD_BITS;
  localparam int RECT_EDGES = 4;

  localparam logic [CW:0] MAX_CNT = (CW+1)'(MAX_SEGMENTS);

  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_TOP    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [EW-1:0] seg_mem [MAX_SEGMENTS];
  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;

  func_t                   func_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic [1:0]              edge_q;
  logic [CW-1:0]           count;
  status_t                 status_q;
  logic                    cross_q;
  logic                    calc_go;

  logic                    in_accept;
  logic                    out_free;
  logic [CW:0]             count_ext;
  logic                    fits1, fits4, idx_ok;
  logic                    write_last;
  logic                    eval_done, eval_crossing;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign count_ext = {1'b0, count};
  assign fits1     = (count_ext + (CW+1)'(1)) <= MAX_CNT;
  assign fits4     = (count_ext + (CW+1)'(RECT_EDGES)) <= MAX_CNT;
  assign idx_ok    = CMPW'(entry_index) < CMPW'(count);
  assign write_last = (func_q != FUNC_RECT) || (edge_q == EDGE_TOP);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (func)
            FUNC_SEGMENT: state_next = fits1 ? ST_WRITE : ST_DONE;
            FUNC_RECT:    state_next = fits4 ? ST_WRITE : ST_DONE;
            FUNC_TEST:    state_next = idx_ok ? ST_CALC : ST_DONE;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_WRITE: begin
        if (write_last) state_next = ST_DONE;
      end
      ST_CALC: begin
        if (eval_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Entry layout: {x0, y0, x1, y1}
  always_comb begin
    if (func_q != FUNC_RECT) begin
      wr_data = {ax_q, ay_q, bx_q, by_q};
    end else begin
      case (edge_q)
        EDGE_LEFT:   wr_data = {ax_q, ay_q, ax_q, by_q};
        EDGE_BOTTOM: wr_data = {ax_q, ay_q, bx_q, ay_q};
        EDGE_RIGHT:  wr_data = {bx_q, ay_q, bx_q, by_q};
        default:     wr_data = {ax_q, by_q, bx_q, by_q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      seg_mem[count[AW-1:0]] <= wr_data;
    end
  end

  // Read the tested entry at accept; data is ready in the first calc cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= seg_mem[AW'(entry_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q <= func;
      ax_q   <= point_a_x;
      ay_q   <= point_a_y;
      bx_q   <= point_b_x;
      by_q   <= point_b_y;
      edge_q <= EDGE_LEFT;
      cross_q <= 1'b0;
      case (func)
        FUNC_SEGMENT: status_q <= fits1 ? STATUS_OK : STATUS_FULL;
        FUNC_RECT:    status_q <= fits4 ? STATUS_OK : STATUS_FULL;
        FUNC_TEST:    status_q <= idx_ok ? STATUS_OK : STATUS_BAD_INDEX;
        default:      status_q <= STATUS_OK;
      endcase
    end else begin
      if (state == ST_WRITE) edge_q <= edge_q + 2'd1;
      if (state == ST_CALC && eval_done) cross_q <= eval_crossing;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      crossing     <= cross_q;
      status       <= status_q;
      stored_count <= COUNT_OUT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      calc_go   <= 1'b0;
    end else begin
      state   <= state_next;
      calc_go <= in_accept && (func == FUNC_TEST) && idx_ok;
      if (state == ST_WRITE) count <= count + CW'(1);
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  stc_cross_eval #(
    .COORD_BITS(COORD_BITS)
  ) u_cross_eval (
    .clk      (clk),
    .rst      (rst),
    .start    (calc_go),
    .ax       (ax_q),
    .ay       (ay_q),
    .bx       (bx_q),
    .by       (by_q),
    .cx       (rd_data[4*COORD_BITS-1:3*COORD_BITS]),
    .cy       (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
    .dx       (rd_data[2*COORD_BITS-1:COORD_BITS]),
    .dy       (rd_data[COORD_BITS-1:0]),
    .done     (eval_done),
    .crossing (eval_crossing)
  );

endmodule

// ===== src/stc_checker.sv =====
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the segment table crossing test block, bound to it.
// ----------------------------------------------------------------------------
module stc_checker #(
  parameter int MAX_SEGMENTS = 128
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         crossing,
  input stc_pkg::status_t             status,
  input stc_pkg::count_out_t          stored_count
);

  import stc_pkg::*;

  localparam int CNT_LIMIT = (MAX_SEGMENTS > 255) ? 255 : MAX_SEGMENTS;

  // A failed store or a bad index never reports a crossing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> !crossing)
    else $error("crossing reported with non-ok status");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stored_count <= COUNT_OUT_W'(CNT_LIMIT))
    else $error("stored count beyond table size");

  // One item in flight: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(crossing) && $stable(status) &&
      $stable(stored_count))
    else $error("stalled result word changed");

endmodule

bind segment_table_crossing_test stc_checker #(
  .MAX_SEGMENTS(MAX_SEGMENTS)
) u_stc_checker (.*);
